>>> src/ciur_pkg.sv
`default_nettype none
package ciur_pkg;

   // Frame identifiers of the update protocol.
   localparam logic [10:0] ID_SYNC  = 11'h320;
   localparam logic [10:0] ID_START = 11'h321;
   localparam logic [10:0] ID_DATA  = 11'h322;
   localparam logic [10:0] ID_END   = 11'h323;

   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
   localparam logic [31:0] FOOTER_MAGIC = 32'h454E4431;
   localparam logic [63:0] SYNC_TOKEN   = 64'h21434E595341544F;
   localparam logic [3:0]  SEQ_BYTES    = 4'd2;
   localparam logic [31:0] FIRST_SECTOR_A = 32'd4;
   localparam logic [31:0] FIRST_SECTOR_B = 32'd6;
   localparam logic [3:0]  CHUNK_BYTES  = 4'd4;

   typedef enum logic [2:0] {
      K_ACK    = 3'd0,
      K_NACK   = 3'd1,
      K_ERASE  = 3'd2,
      K_WRITE  = 3'd3,
      K_COMMIT = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      E_OK    = 3'd0,
      E_PROTO = 3'd1,
      E_FLASH = 3'd2,
      E_SIZE  = 3'd3,
      E_CRC   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HEADER = 2'd1,
      PH_RECV   = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] R_ACTIVE = 3'd0;
   localparam logic [2:0] R_A_BASE = 3'd1;
   localparam logic [2:0] R_B_BASE = 3'd2;
   localparam logic [2:0] R_A_SIZE = 3'd3;
   localparam logic [2:0] R_B_SIZE = 3'd4;
   localparam logic [2:0] R_A_VER  = 3'd5;
   localparam logic [2:0] R_B_VER  = 3'd6;

   typedef struct packed {
      kind_type   kind;
      status_type status_code;
      logic [31:0] value;
      logic [31:0] flash_address;
      logic [31:0] flash_word;
      logic        slot;
      logic [31:0] image_size;
      logic [31:0] image_crc;
      logic [31:0] image_version;
      logic        record_error;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0]  active_slot;
      logic [31:0] a_base;
      logic [31:0] b_base;
      logic [31:0] a_size;
      logic [31:0] b_size;
      logic [31:0] a_ver;
      logic [31:0] b_ver;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic        target_slot;
      logic [31:0] want_size;
      logic [31:0] want_crc;
      logic [31:0] new_version;
      logic [31:0] got_size;
      logic [31:0] crc_acc;
      logic [31:0] write_ptr;
      logic [15:0] next_seq;
   } session_type;

   // One byte folded into the reflected CRC.
   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic result_type blank_result(input kind_type k);
      result_type r;
      r = '0;
      r.kind = k;
      return r;
   endfunction

   function automatic result_type status_result(input kind_type k, input status_type s,
                                                input logic [31:0] v, input logic rec);
      result_type r;
      r = blank_result(k);
      r.status_code = s;
      r.value = v;
      r.record_error = rec;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic session_type reset_session();
      session_type s;
      s = '0;
      s.phase = PH_IDLE;
      s.target_slot = 1'b1;
      s.crc_acc = CRC_INIT;
      return s;
   endfunction

endpackage
`default_nettype wire

>>> src/can_image_update_receiver_top.sv
// CAN image-update receiver.
// Input channel req_*: one received CAN frame per word (id, length, 8 bytes).
// Result channel rsp_*: zero, one or two result words per frame, the final
// one flagged by rsp_last. csr_*: write-only register port, index 0..6.
// A frame is registered on acceptance; the protocol logic then evaluates it
// against the session state and, once the buffer can take them, loads up to
// two results into a two-entry result buffer, from which they leave one word
// at a time. A new frame can be taken while the previous frame's results
// still drain; the result buffer's drain rate sets throughput. Frames
// producing no result are absorbed silently.
// When the receiver stalls rsp_ready, results hold and req_ready drops once
// the buffer cannot take another frame's results.
// Synchronous reset clears the session to idle, target slot B, CRC all
// ones, and registers to their defaults (active slot invalid).
`default_nettype none
module can_image_update_receiver_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [10:0] req_frame_id,
   input  wire logic [3:0]  req_frame_len,
   input  wire logic [63:0] req_frame_bytes,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_kind,
   output logic [2:0]       rsp_status_code,
   output logic [31:0]      rsp_value,
   output logic [31:0]      rsp_flash_address,
   output logic [31:0]      rsp_flash_word,
   output logic             rsp_slot,
   output logic [31:0]      rsp_image_size,
   output logic [31:0]      rsp_image_crc,
   output logic [31:0]      rsp_image_version,
   output logic             rsp_record_error,
   output logic             rsp_last,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import ciur_pkg::*;

   cfg_type     cfg;
   session_type sess_ff, sess_in;
   result_type  r0, r1;
   logic [1:0]  rcount;
   logic        in_valid_ff;
   logic [10:0] id_ff;
   logic [3:0]  len_ff;
   logic [63:0] bytes_ff;
   result_type  buf_ff [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        pop, fire, adv;

   ciur_csr u_csr (
      .clock(clock), .reset(reset), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data), .cfg(cfg)
   );

   ciur_proto u_proto (
      .cfg(cfg), .sess(sess_ff), .frame_id(id_ff), .frame_len(len_ff),
      .frame_bytes(bytes_ff), .sess_next(sess_in), .res0(r0), .res1(r1),
      .res_count(rcount)
   );

   // The staged frame moves into the buffer when the buffer is empty after pop.
   assign pop  = rsp_valid && rsp_ready;
   assign adv  = in_valid_ff && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop));
   assign req_ready = !in_valid_ff || adv;
   assign fire = req_valid && req_ready;

   always_comb begin
      cnt_in = cnt_ff - {1'b0, pop};
      if (adv) begin
         cnt_in = rcount;
      end
   end

   // Input register and session state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         sess_ff <= reset_session();
         cnt_ff <= 2'd0;
      end else begin
         if (fire) begin
            in_valid_ff <= 1'b1;
         end else if (adv) begin
            in_valid_ff <= 1'b0;
         end
         if (adv) begin
            sess_ff <= sess_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   // Frame payload and result buffer.
   always_ff @(posedge clock) begin
      if (fire) begin
         id_ff <= req_frame_id;
         len_ff <= req_frame_len;
         bytes_ff <= req_frame_bytes;
      end
      if (adv) begin
         buf_ff[0] <= r0;
         buf_ff[1] <= r1;
      end else if (pop) begin
         buf_ff[0] <= buf_ff[1];
      end
   end

   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_kind = buf_ff[0].kind;
   assign rsp_status_code = buf_ff[0].status_code;
   assign rsp_value = buf_ff[0].value;
   assign rsp_flash_address = buf_ff[0].flash_address;
   assign rsp_flash_word = buf_ff[0].flash_word;
   assign rsp_slot = buf_ff[0].slot;
   assign rsp_image_size = buf_ff[0].image_size;
   assign rsp_image_crc = buf_ff[0].image_crc;
   assign rsp_image_version = buf_ff[0].image_version;
   assign rsp_record_error = buf_ff[0].record_error;
   assign rsp_last = buf_ff[0].last;
endmodule
`default_nettype wire

>>> src/ciur_csr.sv
`default_nettype none
module ciur_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   output ciur_pkg::cfg_type       cfg
);
   import ciur_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Register file write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            R_ACTIVE: cfg_in.active_slot = csr_data[1:0];
            R_A_BASE: cfg_in.a_base = csr_data;
            R_B_BASE: cfg_in.b_base = csr_data;
            R_A_SIZE: cfg_in.a_size = csr_data;
            R_B_SIZE: cfg_in.b_size = csr_data;
            R_A_VER:  cfg_in.a_ver = csr_data;
            R_B_VER:  cfg_in.b_ver = csr_data;
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   // Reset leaves the active slot marked invalid and everything else zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_type'({2'd2, 192'd0});
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

>>> src/ciur_proto.sv
`default_nettype none
module ciur_proto (
   input  wire ciur_pkg::cfg_type     cfg,
   input  wire ciur_pkg::session_type sess,
   input  wire logic [10:0]           frame_id,
   input  wire logic [3:0]            frame_len,
   input  wire logic [63:0]           frame_bytes,
   output ciur_pkg::session_type      sess_next,
   output ciur_pkg::result_type       res0,
   output ciur_pkg::result_type       res1,
   output logic [1:0]                 res_count
);
   import ciur_pkg::*;

   logic [31:0] lo, hi, lim, base, word, crc, fin;
   logic [3:0]  plen;
   logic [32:0] sum;
   logic        tslot;
   logic [7:0]  b;

   // Decision logic for one frame; at most two results.
   always_comb begin
      lo = frame_bytes[31:0];
      hi = frame_bytes[63:32];
      lim  = sess.target_slot ? cfg.b_size : cfg.a_size;
      base = sess.target_slot ? cfg.b_base : cfg.a_base;
      plen = frame_len - SEQ_BYTES;
      sum = {1'b0, sess.got_size} + {29'd0, plen[2:0]};
      fin = ~sess.crc_acc;
      tslot = (cfg.active_slot == 2'd1) ? 1'b0 : 1'b1;
      word = '0;
      crc = sess.crc_acc;
      for (int i = 0; i < 4; i++) begin
         b = frame_bytes[8*(i+2) +: 8];
         if (4'(i) < plen) begin
            word[8*i +: 8] = b;
            crc = crc_byte(crc, b);
         end
      end
      sess_next = sess;
      res0 = blank_result(K_ACK);
      res1 = blank_result(K_ACK);
      res_count = 2'd0;
      if (frame_len > 4'd8) begin
         res0 = status_result(K_NACK, E_PROTO, '0, 1'b0);
         res_count = 2'd1;
      end else if (frame_id == ID_SYNC) begin
         res_count = 2'd1;
         if (frame_len == 4'd8 && frame_bytes == SYNC_TOKEN) begin
            sess_next = reset_session();
            sess_next.target_slot = tslot;
            sess_next.new_version = (tslot ? cfg.b_ver : cfg.a_ver) + 32'd1;
            sess_next.phase = PH_HEADER;
            res0 = status_result(K_ACK, E_OK, {31'd0, tslot}, 1'b0);
         end else begin
            res0 = status_result(K_NACK, E_PROTO, '0, 1'b0);
         end
      end else if (frame_id == ID_START) begin
         res_count = 2'd1;
         if (sess.phase == PH_RECV && sess.got_size == '0 && sess.want_size == lo
             && sess.want_crc == hi) begin
            res0 = status_result(K_ACK, E_OK, sess.want_size, 1'b0);
         end else if (sess.phase != PH_HEADER) begin
            res0 = status_result(K_NACK, E_PROTO, '0, 1'b0);
         end else if (lo == '0 || lo > lim) begin
            res0 = status_result(K_NACK, E_SIZE, lo, 1'b1);
            sess_next = reset_session();
         end else begin
            res0 = blank_result(K_ERASE);
            res0.value = sess.target_slot ? FIRST_SECTOR_B : FIRST_SECTOR_A;
            res0.flash_address = base;
            res0.slot = sess.target_slot;
            res1 = status_result(K_ACK, E_OK, lo, 1'b0);
            res_count = 2'd2;
            sess_next.want_size = lo;
            sess_next.want_crc = hi;
            sess_next.phase = PH_RECV;
            sess_next.got_size = '0;
            sess_next.crc_acc = CRC_INIT;
            sess_next.write_ptr = base;
         end
      end else if (frame_id == ID_DATA) begin
         res_count = 2'd1;
         if (sess.phase != PH_RECV) begin
            res0 = status_result(K_NACK, E_PROTO, '0, 1'b0);
         end else if (frame_len <= SEQ_BYTES) begin
            res0 = status_result(K_NACK, E_PROTO, '0, 1'b0);
            sess_next = reset_session();
         end else if (lo[15:0] != sess.next_seq) begin
            res0 = status_result(K_NACK, E_PROTO, {16'd0, sess.next_seq}, 1'b0);
            sess_next = reset_session();
         end else if (sum > {1'b0, sess.want_size}) begin
            res0 = status_result(K_NACK, E_SIZE, sess.got_size, 1'b1);
            sess_next = reset_session();
         end else if (plen > CHUNK_BYTES) begin
            res0 = status_result(K_NACK, E_FLASH, sess.got_size, 1'b1);
            sess_next = reset_session();
         end else begin
            res0 = blank_result(K_WRITE);
            res0.flash_address = sess.write_ptr;
            res0.flash_word = word;
            res1 = status_result(K_ACK, E_OK, sum[31:0], 1'b0);
            res_count = 2'd2;
            sess_next.crc_acc = crc;
            sess_next.got_size = sum[31:0];
            sess_next.next_seq = sess.next_seq + 16'd1;
            sess_next.write_ptr = sess.write_ptr + {28'd0, CHUNK_BYTES};
         end
      end else if (frame_id == ID_END) begin
         res_count = 2'd1;
         if (sess.phase != PH_RECV) begin
            res0 = status_result(K_NACK, E_PROTO, '0, 1'b0);
         end else if (frame_len != 4'd8) begin
            res0 = status_result(K_NACK, E_PROTO, '0, 1'b0);
            sess_next = reset_session();
         end else if (lo != FOOTER_MAGIC || hi != sess.want_size) begin
            res0 = status_result(K_NACK, E_PROTO, hi, 1'b0);
            sess_next = reset_session();
         end else if (sess.got_size != sess.want_size || fin != sess.want_crc) begin
            res0 = status_result(K_NACK, E_CRC, fin, 1'b1);
            sess_next = reset_session();
         end else begin
            res0 = blank_result(K_COMMIT);
            res0.slot = sess.target_slot;
            res0.image_size = sess.want_size;
            res0.image_crc = fin;
            res0.image_version = sess.new_version;
            res1 = status_result(K_ACK, E_OK, fin, 1'b0);
            res_count = 2'd2;
            sess_next.phase = PH_DONE;
         end
      end
   end
endmodule
`default_nettype wire

>>> src/ciur_checker.sv
`default_nettype none
module ciur_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_kind,
   input wire logic [2:0]  rsp_status_code,
   input wire logic        rsp_last
);
   // Results that are held must stay valid until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // Erase, write and commit words are never the final word of a frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == 3'd2 || rsp_kind == 3'd3 || rsp_kind == 3'd4)
      |-> !rsp_last)
      else $error("data-side word flagged last");

   // An acknowledge always carries status ok.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == 3'd0 |-> rsp_status_code == 3'd0)
      else $error("ack with error status");

   // A negative acknowledge ends its frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == 3'd1 |-> rsp_last)
      else $error("nack not final");
endmodule

bind can_image_update_receiver_top ciur_checker u_ciur_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
   .rsp_status_code(rsp_status_code), .rsp_last(rsp_last)
);
`default_nettype wire

>>> tb/can_image_update_receiver_top_test.sv
`timescale 1ns / 100ps
module can_image_update_receiver_top_test;
   import ciur_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [10:0] req_frame_id;
   logic [3:0]  req_frame_len;
   logic [63:0] req_frame_bytes;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_kind;
   logic [2:0]  rsp_status_code;
   logic [31:0] rsp_value;
   logic [31:0] rsp_flash_address;
   logic [31:0] rsp_flash_word;
   logic        rsp_slot;
   logic [31:0] rsp_image_size;
   logic [31:0] rsp_image_crc;
   logic [31:0] rsp_image_version;
   logic        rsp_record_error;
   logic        rsp_last;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   can_image_update_receiver_top dut (.*);

   localparam logic [10:0] ID_QUERY_FRAME = 11'h326;

   // Shadow registers and session state of the receiver.
   cfg_type     shadow_cfg;
   phase_type   sess_phase;
   logic        sess_slot;
   logic [31:0] sess_want_size;
   logic [31:0] sess_want_crc;
   logic [31:0] sess_version;
   logic [31:0] sess_got_size;
   logic [31:0] sess_crc;
   logic [31:0] sess_wptr;
   logic [15:0] sess_seq;

   result_type  pending_results[$];
   int          fail_count = 0;
   int          words_sent = 0;
   int          stall_cycles = 0;
   bit          calm = 0;

   // Clock.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [31:0] fold_byte(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] c;
      c = acc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void drop_session();
      sess_phase = PH_IDLE;
      sess_slot = 1'b1;
      sess_want_size = '0;
      sess_want_crc = '0;
      sess_version = '0;
      sess_got_size = '0;
      sess_crc = 32'hFFFFFFFF;
      sess_wptr = '0;
      sess_seq = '0;
   endfunction

   // A status word always closes the results of a frame.
   function automatic void expect_status(input kind_type k, input status_type s,
                                         input logic [31:0] v, input logic rec);
      result_type r;
      r = '0;
      r.kind = k;
      r.status_code = s;
      r.value = v;
      r.record_error = rec;
      r.last = 1'b1;
      pending_results.push_back(r);
   endfunction

   // Works out the results of one accepted frame and advances the session.
   function automatic void predict_frame(input logic [10:0] id, input logic [3:0] len,
                                         input logic [63:0] bytes);
      logic [31:0] lo, hi, lim, base, word, fin;
      logic [3:0]  plen;
      result_type  r;
      lo = bytes[31:0];
      hi = bytes[63:32];
      r = '0;
      lim = sess_slot ? shadow_cfg.b_size : shadow_cfg.a_size;
      base = sess_slot ? shadow_cfg.b_base : shadow_cfg.a_base;
      if (len > 4'd8) begin
         expect_status(K_NACK, E_PROTO, '0, 1'b0);
      end else if (id == ID_SYNC) begin
         if (len == 4'd8 && bytes == 64'h21434E595341544F) begin
            drop_session();
            sess_slot = (shadow_cfg.active_slot == 2'd1) ? 1'b0 : 1'b1;
            sess_version = (sess_slot ? shadow_cfg.b_ver : shadow_cfg.a_ver) + 32'd1;
            sess_phase = PH_HEADER;
            expect_status(K_ACK, E_OK, {31'd0, sess_slot}, 1'b0);
         end else begin
            expect_status(K_NACK, E_PROTO, '0, 1'b0);
         end
      end else if (id == ID_START) begin
         if (sess_phase == PH_RECV && sess_got_size == 0 && sess_want_size == lo
             && sess_want_crc == hi) begin
            expect_status(K_ACK, E_OK, sess_want_size, 1'b0);
         end else if (sess_phase != PH_HEADER) begin
            expect_status(K_NACK, E_PROTO, '0, 1'b0);
         end else if (lo == 0 || lo > lim) begin
            expect_status(K_NACK, E_SIZE, lo, 1'b1);
            drop_session();
         end else begin
            r.kind = K_ERASE;
            r.value = sess_slot ? 32'd6 : 32'd4;
            r.flash_address = base;
            r.slot = sess_slot;
            pending_results.push_back(r);
            sess_want_size = lo;
            sess_want_crc = hi;
            sess_phase = PH_RECV;
            sess_got_size = '0;
            sess_crc = 32'hFFFFFFFF;
            sess_wptr = base;
            expect_status(K_ACK, E_OK, lo, 1'b0);
         end
      end else if (id == ID_DATA) begin
         plen = len - 4'd2;
         if (sess_phase != PH_RECV) begin
            expect_status(K_NACK, E_PROTO, '0, 1'b0);
         end else if (len <= 4'd2) begin
            expect_status(K_NACK, E_PROTO, '0, 1'b0);
            drop_session();
         end else if (lo[15:0] != sess_seq) begin
            expect_status(K_NACK, E_PROTO, {16'd0, sess_seq}, 1'b0);
            drop_session();
         end else if ({1'b0, sess_got_size} + 33'(plen) > {1'b0, sess_want_size}) begin
            expect_status(K_NACK, E_SIZE, sess_got_size, 1'b1);
            drop_session();
         end else if (plen > 4'd4) begin
            expect_status(K_NACK, E_FLASH, sess_got_size, 1'b1);
            drop_session();
         end else begin
            word = '0;
            for (int k = 0; k < plen; k++) begin
               word[8*k +: 8] = bytes[8*(k+2) +: 8];
               sess_crc = fold_byte(sess_crc, bytes[8*(k+2) +: 8]);
            end
            r.kind = K_WRITE;
            r.flash_address = sess_wptr;
            r.flash_word = word;
            pending_results.push_back(r);
            sess_got_size = sess_got_size + 32'(plen);
            sess_seq = sess_seq + 16'd1;
            sess_wptr = sess_wptr + 32'd4;
            expect_status(K_ACK, E_OK, sess_got_size, 1'b0);
         end
      end else if (id == ID_END) begin
         fin = ~sess_crc;
         if (sess_phase != PH_RECV) begin
            expect_status(K_NACK, E_PROTO, '0, 1'b0);
         end else if (len != 4'd8) begin
            expect_status(K_NACK, E_PROTO, '0, 1'b0);
            drop_session();
         end else if (lo != 32'h454E4431 || hi != sess_want_size) begin
            expect_status(K_NACK, E_PROTO, hi, 1'b0);
            drop_session();
         end else if (sess_got_size != sess_want_size || fin != sess_want_crc) begin
            expect_status(K_NACK, E_CRC, fin, 1'b1);
            drop_session();
         end else begin
            r.kind = K_COMMIT;
            r.slot = sess_slot;
            r.image_size = sess_want_size;
            r.image_crc = fin;
            r.image_version = sess_version;
            pending_results.push_back(r);
            sess_phase = PH_DONE;
            expect_status(K_ACK, E_OK, fin, 1'b0);
         end
      end
   endfunction

   // Sends one frame word and predicts its results once it is taken.
   task automatic send_frame(input logic [10:0] id, input logic [3:0] len,
                             input logic [63:0] bytes);
      if (!calm && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frame_id <= id;
      req_frame_len <= len;
      req_frame_bytes <= bytes;
      do @(posedge clock); while (!req_ready);
      predict_frame(id, len, bytes);
      words_sent++;
   endtask

   // Waits until the block has nothing left to deliver.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes all seven registers on consecutive cycles.
   task automatic configure(input logic [1:0] act, input logic [31:0] ab, input logic [31:0] bb,
                            input logic [31:0] asz, input logic [31:0] bsz,
                            input logic [31:0] av, input logic [31:0] bv);
      logic [31:0] vals[7];
      logic [2:0]  idx[7];
      vals = '{{30'd0, act}, ab, bb, asz, bsz, av, bv};
      idx = '{R_ACTIVE, R_A_BASE, R_B_BASE, R_A_SIZE, R_B_SIZE, R_A_VER, R_B_VER};
      for (int k = 0; k < 7; k++) begin
         csr_write <= 1'b1;
         csr_index <= idx[k];
         csr_data <= vals[k];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      shadow_cfg.active_slot = act;
      shadow_cfg.a_base = ab;
      shadow_cfg.b_base = bb;
      shadow_cfg.a_size = asz;
      shadow_cfg.b_size = bsz;
      shadow_cfg.a_ver = av;
      shadow_cfg.b_ver = bv;
   endtask

   function automatic logic [31:0] image_crc_of(input logic [7:0] img[64], input int n);
      logic [31:0] c;
      c = 32'hFFFFFFFF;
      for (int k = 0; k < n; k++) c = fold_byte(c, img[k]);
      return ~c;
   endfunction

   function automatic logic [63:0] data_bytes(input logic [15:0] seq, input logic [7:0] img[64],
                                              input int off, input int plen);
      logic [63:0] b;
      b = {$urandom, $urandom};
      b[15:0] = seq;
      for (int k = 0; k < plen && k < 6; k++) b[8*(k+2) +: 8] = img[(off + k) % 64];
      return b;
   endfunction

   // Directed frames: every identifier, some of the error paths and a clean session.
   task automatic test_directed();
      logic [7:0]  img[64];
      logic [31:0] crc;
      for (int k = 0; k < 64; k++) img[k] = $urandom;
      crc = image_crc_of(img, 6);
      configure(2'd2, 32'h1000, 32'h8000, 32'd64, 32'd64, 32'd5, 32'hFFFFFFFF);
      send_frame(ID_SYNC, 4'd15, 64'h21434E595341544F);
      send_frame(ID_QUERY_FRAME, 4'd8, '1);
      send_frame(11'd0, 4'd0, '0);
      send_frame(ID_DATA, 4'd6, 64'd0);
      send_frame(ID_END, 4'd8, {32'd6, 32'h454E4431});
      send_frame(ID_START, 4'd8, {32'd0, 32'd6});
      send_frame(ID_SYNC, 4'd7, 64'h21434E595341544F);
      send_frame(ID_SYNC, 4'd8, 64'h21434E595341544E);
      send_frame(ID_SYNC, 4'd8, 64'h21434E595341544F);
      send_frame(ID_START, 4'd8, {crc, 32'd0});
      send_frame(ID_SYNC, 4'd8, 64'h21434E595341544F);
      send_frame(ID_START, 4'd8, {crc, 32'd65});
      send_frame(ID_SYNC, 4'd8, 64'h21434E595341544F);
      send_frame(ID_START, 4'd8, {crc, 32'd6});
      send_frame(ID_START, 4'd8, {crc, 32'd6});
      send_frame(ID_DATA, 4'd6, data_bytes(16'd0, img, 0, 4));
      send_frame(ID_DATA, 4'd4, data_bytes(16'd1, img, 4, 2));
      send_frame(ID_END, 4'd8, {32'd6, 32'h454E4431});
      send_frame(ID_DATA, 4'd6, data_bytes(16'd2, img, 6, 4));
      send_frame(ID_SYNC, 4'd8, 64'h21434E595341544F);
      send_frame(ID_START, 4'd8, {32'd0, 32'd8});
      send_frame(ID_DATA, 4'd2, 64'd0);
      send_frame(ID_SYNC, 4'd8, 64'h21434E595341544F);
      send_frame(ID_START, 4'd8, {32'd0, 32'd4});
      send_frame(ID_DATA, 4'd8, data_bytes(16'd0, img, 0, 6));
      drain();
   endtask

   // One upload session, mostly well formed, sometimes broken on purpose.
   task automatic run_session();
      logic [7:0]  img[64];
      logic [31:0] size, crc, lim;
      logic [15:0] seq;
      int          fault, off, plen, bad_chunk, chunk;
      fault = $urandom_range(0, 24);
      for (int k = 0; k < 64; k++) img[k] = $urandom;
      if (fault == 0)
         send_frame(ID_SYNC, 4'd8, {$urandom, $urandom});
      else
         send_frame(ID_SYNC, 4'd8, 64'h21434E595341544F);
      if (fault == 1)
         send_frame(11'($urandom), 4'($urandom), {$urandom, $urandom});
      size = $urandom_range(1, 48);
      lim = sess_slot ? shadow_cfg.b_size : shadow_cfg.a_size;
      if (fault == 2) size = (lim == 32'hFFFFFFFF) ? 32'd0 : lim + 32'd1;
      crc = image_crc_of(img, size > 48 ? 48 : int'(size));
      if (fault == 3) crc = crc ^ (32'd1 << $urandom_range(31));
      send_frame(ID_START, 4'd8, {crc, size});
      if (fault == 4) send_frame(ID_START, 4'd8, {crc, size});
      off = 0;
      seq = 0;
      chunk = 0;
      bad_chunk = $urandom_range(0, 6);
      while (off < int'(size) && off < 48) begin
         plen = $urandom_range(1, 4);
         if (plen > int'(size) - off) plen = int'(size) - off;
         if (fault == 5 && chunk == bad_chunk) plen = $urandom_range(5, 6);
         if (fault == 6 && chunk == bad_chunk) plen = plen + 1;
         if (fault == 7 && chunk == bad_chunk) seq = seq ^ 16'(1 << $urandom_range(15));
         if (fault == 8 && off + plen >= int'(size)) break;
         send_frame(ID_DATA, 4'(plen + 2), data_bytes(seq, img, off, plen));
         off += plen;
         seq++;
         chunk++;
      end
      case (fault)
         9: send_frame(ID_END, 4'($urandom_range(0, 7)), {size, 32'h454E4431});
         10: send_frame(ID_END, 4'd8, {size, $urandom});
         11: send_frame(ID_END, 4'd8, {size + 32'd1, 32'h454E4431});
         default: send_frame(ID_END, 4'd8, {size, 32'h454E4431});
      endcase
      if (fault == 12) send_frame(ID_DATA, 4'($urandom), {$urandom, $urandom});
   endtask

   // Random sessions under several register settings, the extremes among them.
   task automatic test_random_sessions();
      int goal;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(2'd0, 32'h0, 32'hFFFFFFF0, 32'hFFFFFFFF, 32'd64, 32'd0, 32'd7);
            1: configure(2'd1, 32'hFFFFFFFC, 32'h0, 32'd48, 32'd0, 32'hFFFFFFFF, 32'd3);
            2: configure(2'd3, $urandom, $urandom, 32'd40, 32'd40, $urandom, $urandom);
            3: configure(2'd2, 32'h08000000, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'd1, 32'd2);
            4: configure(2'd0, $urandom, $urandom, 32'd0, 32'd0, $urandom, $urandom);
            default: configure(2'd2, $urandom, $urandom, 32'd20, 32'd30, $urandom, $urandom);
         endcase
         calm = (phase == 2);
         goal = (phase == 4) ? words_sent + 30 : words_sent + 160;
         while (words_sent < goal) begin
            if ($urandom_range(9) == 0)
               send_frame(11'($urandom), 4'($urandom), {$urandom, $urandom});
            else
               run_session();
         end
         calm = 0;
         drain();
      end
   endtask

   // The receiver holds off for a long stretch so the block fills and stalls.
   task automatic test_backpressure();
      configure(2'd1, 32'h100, 32'h200, 32'd32, 32'd32, 32'd9, 32'd9);
      stall_cycles = 300;
      for (int k = 0; k < 4; k++) run_session();
      drain();
   endtask

   // Result side ready, with random stalls and one long hold-off.
   always @(posedge clock) begin
      if (stall_cycles > 0) begin
         stall_cycles <= stall_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 6);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Compares each result word with the oldest expectation.
   always @(posedge clock) begin
      result_type r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected, kind %0d", rsp_kind);
            fail_count++;
         end else begin
            r = pending_results.pop_front();
            check_field("kind", 32'(r.kind), 32'(rsp_kind));
            check_field("status_code", 32'(r.status_code), 32'(rsp_status_code));
            check_field("value", r.value, rsp_value);
            check_field("flash_address", r.flash_address, rsp_flash_address);
            check_field("flash_word", r.flash_word, rsp_flash_word);
            check_field("slot", 32'(r.slot), 32'(rsp_slot));
            check_field("image_size", r.image_size, rsp_image_size);
            check_field("image_crc", r.image_crc, rsp_image_crc);
            check_field("image_version", r.image_version, rsp_image_version);
            check_field("record_error", 32'(r.record_error), 32'(rsp_record_error));
            check_field("last", 32'(r.last), 32'(rsp_last));
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_frame_id <= '0;
      req_frame_len <= '0;
      req_frame_bytes <= '0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      shadow_cfg = '0;
      shadow_cfg.active_slot = 2'd2;
      drop_session();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_sessions();
      drain();
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("[can_image_update_receiver_top] OK");
      end else begin
         $display("[can_image_update_receiver_top] ERROR");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #8_000_000;
      $display("[can_image_update_receiver_top] ERROR");
      $finish;
   end

endmodule
